// ===== hw/rtl/sia_pkg.sv =====
`default_nettype none

package sia_pkg;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned IDX_BYTES = 2;

  localparam int unsigned ID_W    = 64;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_EXHAUSTED = 2'd2,
    STATUS_REJECTED  = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sia_ram.sv =====
`default_nettype none

module sia_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/session_id_allocator.sv =====
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+----------------------------------------------
// in      | input     | in_valid_i / in_ready_o | req_type_i, release_id_i
// out     | output    | out_valid_o/ out_ready_i| status_o, new_id_o, slot_index_o, free_count_o
//
// The free stack RAM is read in the accept cycle; the result is computed and written back
// in the execute state, and no new item is accepted until that state is left.
// The result sits in an output register; the block accepts the next item while it waits.
// A full output register stalls the execute state until the result is taken.
// After reset the block is ready at once: entries below a low-water mark were never
// written and their value is computed from the count, so no clearing pass is needed.
`default_nettype none

module session_id_allocator #(
  parameter int unsigned Capacity = sia_pkg::CAPACITY,
  parameter int unsigned IdxBytes = sia_pkg::IDX_BYTES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          req_type_i,
  input  wire logic [sia_pkg::ID_W-1:0]      release_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [1:0]                    status_o,
  output logic      [sia_pkg::ID_W-1:0]      new_id_o,
  output logic      [sia_pkg::SLOT_W-1:0]    slot_index_o,
  output logic      [sia_pkg::COUNT_W-1:0]   free_count_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned SeqW = sia_pkg::ID_W - 8 * IdxBytes;

  sia_pkg::state_e state_q, state_d;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          lw_q, lw_d;
  logic [SeqW:0]            seq_q, seq_d;
  logic                     req_q;
  logic [sia_pkg::ID_W-1:0] rel_id_q;

  logic                     out_valid_q, out_valid_d;
  sia_pkg::status_e         status_q, status_d;
  logic [sia_pkg::ID_W-1:0] new_id_q, new_id_d;
  logic [sia_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [sia_pkg::COUNT_W-1:0] free_q, free_d;

  logic                     in_acc;
  logic                     go;
  logic                     ram_we;
  logic [IdxW-1:0]          ram_waddr;
  logic [IdxW-1:0]          ram_wdata;
  logic [IdxW-1:0]          ram_raddr;
  logic [IdxW-1:0]          ram_rdata;
  logic [IdxW-1:0]          pop_idx;
  logic [sia_pkg::ID_W-1:0] rel_idx;

  assign in_ready_o = (state_q == sia_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign go         = !out_valid_q || out_ready_i;
  assign ram_raddr  = IdxW'(cnt_q - CntW'(1));
  assign rel_idx    = rel_id_q >> SeqW;

  always_comb begin
    if (cnt_q == lw_q) begin
      pop_idx = IdxW'(CntW'(Capacity) - cnt_q);
    end else begin
      pop_idx = ram_rdata;
    end
  end

  sia_ram #(
    .Width(IdxW),
    .Depth(Capacity)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lw_d        = lw_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    new_id_d    = new_id_q;
    slot_d      = slot_q;
    free_d      = free_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[IdxW-1:0];
    ram_wdata   = rel_idx[IdxW-1:0];

    case (state_q)
      sia_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = sia_pkg::ST_EXEC;
        end
      end
      sia_pkg::ST_EXEC: begin
        if (go) begin
          state_d     = sia_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          new_id_d    = '0;
          slot_d      = '0;
          if (req_q == sia_pkg::REQ_ALLOC) begin
            if (cnt_q == '0) begin
              status_d = sia_pkg::STATUS_EMPTY;
            end else if (seq_q[SeqW]) begin
              status_d = sia_pkg::STATUS_EXHAUSTED;
            end else begin
              status_d = sia_pkg::STATUS_OK;
              cnt_d    = cnt_q - CntW'(1);
              if (cnt_q == lw_q) begin
                lw_d = cnt_q - CntW'(1);
              end
              seq_d    = seq_q + (SeqW+1)'(1);
              new_id_d = (sia_pkg::ID_W'(pop_idx) << SeqW)
                       | sia_pkg::ID_W'(seq_q[SeqW-1:0]);
              slot_d   = sia_pkg::SLOT_W'(pop_idx);
            end
          end else begin
            slot_d = rel_idx[sia_pkg::SLOT_W-1:0];
            if ((rel_idx >= sia_pkg::ID_W'(Capacity)) || (cnt_q == CntW'(Capacity))) begin
              status_d = sia_pkg::STATUS_REJECTED;
            end else begin
              status_d = sia_pkg::STATUS_OK;
              ram_we   = 1'b1;
              cnt_d    = cnt_q + CntW'(1);
            end
          end
          free_d = sia_pkg::COUNT_W'(cnt_d);
        end
      end
      default: begin
        state_d = sia_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sia_pkg::ST_IDLE;
      cnt_q       <= CntW'(Capacity);
      lw_q        <= CntW'(Capacity);
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lw_q        <= lw_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= req_type_i;
      rel_id_q <= release_id_i;
    end
    status_q <= status_d;
    new_id_q <= new_id_d;
    slot_q   <= slot_d;
    free_q   <= free_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign new_id_o     = new_id_q;
  assign slot_index_o = slot_q;
  assign free_count_o = free_q;

`ifndef SYNTHESIS
  a_count_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lw_q <= cnt_q) && (cnt_q <= CntW'(Capacity)))
    else $error("Free stack count or low-water mark out of bounds.");

  a_seq_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q[SeqW] |-> (seq_q[SeqW-1:0] == '0))
    else $error("Sequence counter ran past its exhausted value.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sia_pkg::ST_EXEC) && !go |=>
      (state_q == sia_pkg::ST_EXEC) && $stable(cnt_q) && $stable(seq_q))
    else $error("State changed while the result register was blocked.");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sia_pkg::ST_EXEC) && go |=> out_valid_q && (state_q == sia_pkg::ST_IDLE))
    else $error("Completed item did not reach the output register.");
`endif

endmodule

`default_nettype wire
